@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console character writer.
`default_nettype none

package tcw_pkg;

	localparam int CHAR_W     = 8;
	localparam int IDX_W      = 11;
	localparam int CELL_W     = 16;
	localparam int ATTR_W     = 8;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int POS_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int TAB_STEP   = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_CELL = 1'd1;

	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd7;
	localparam logic [CELL_W-1:0] BLANK_RESET = 16'd1824;

	// request kinds
	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

	typedef struct packed {
		logic              req_type;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} req_item_t;

	typedef struct packed {
		logic [CELL_W-1:0]    cell_value;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [COL_OUT_W-1:0] cursor_col;
		logic [POS_W-1:0]     cursor_pos;
		logic                 scrolled;
	} rsp_item_t;

	typedef struct packed {
		logic [ATTR_W-1:0] attr;
		logic [CELL_W-1:0] blank;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/tcw_if.sv @@
// Request and response channel interfaces of the text console character writer.
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, req_type, char_code, cell_index, input ready);
	modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CELL_W-1:0]    cell_value;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [COL_OUT_W-1:0] cursor_col;
	logic [POS_W-1:0]     cursor_pos;
	logic                 scrolled;

	modport source (output valid, cell_value, cursor_row, cursor_col, cursor_pos, scrolled,
		input ready);
	modport sink   (input valid, cell_value, cursor_row, cursor_col, cursor_pos, scrolled,
		output ready);
endinterface

`default_nettype wire

@@ rtl/tcw_mem.sv @@
// Screen store: one write port, one read port, registered read data.
`default_nettype none

module tcw_mem import tcw_pkg::*; #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  wire                clk,
	input  wire                we,
	input  wire [ADDR_W-1:0]   waddr,
	input  wire [CELL_W-1:0]   wdata,
	input  wire [ADDR_W-1:0]   raddr,
	output logic [CELL_W-1:0]  rdata
);

	logic [CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/tcw_engine.sv @@
// Cursor state and sequencer: character handling, backspace scan, scroll and clear.
`default_nettype none

module tcw_engine import tcw_pkg::*; #(
	parameter int SCREEN_ROWS = 25,
	parameter int SCREEN_COLS = 80,
	parameter int ADDR_W      = 11
) (
	input  wire               clk,
	input  wire               arst_n,
	input  cfg_t              cfg,
	input  wire               item_valid,
	output logic              item_ready,
	input  req_item_t         item,
	output logic              res_valid,
	input  wire               res_ready,
	output rsp_item_t         res,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic [ADDR_W-1:0] mem_raddr,
	input  wire [CELL_W-1:0]  mem_rdata
);

	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
	localparam int COPY_N     = (SCREEN_ROWS - 1) * SCREEN_COLS;
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);
	localparam int RW         = $clog2(SCREEN_ROWS);
	localparam int CW         = $clog2(SCREEN_COLS);

	localparam logic [2:0] ST_FILL   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_RD     = 3'd2;
	localparam logic [2:0] ST_BS_RD  = 3'd3;
	localparam logic [2:0] ST_BS_CMP = 3'd4;
	localparam logic [2:0] ST_COPY   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              clr_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic              cp_vld_s1;
	logic [ADDR_W-1:0] cp_addr_s1;
	logic [CELL_W-1:0] value_q;
	logic              scr_q;
	logic              rd_ok_q;

	logic [ADDR_W-1:0] cur_addr;
	logic [RW:0]       rowx;
	logic [CW:0]       colx;
	logic [RW:0]       nrow;
	logic [CW:0]       ncol;
	logic [CW:0]       col_t;
	logic              put_we;
	logic [ADDR_W-1:0] put_waddr;
	logic [CELL_W-1:0] put_wdata;
	logic              go_bs;
	logic              wrap_scroll;
	logic              scan_more;
	logic              in_range;

	assign cur_addr    = ADDR_W'(row_q * SCREEN_COLS + col_q);
	assign scan_more   = (mem_rdata == cfg.blank) && (col_q != '0);
	assign in_range    = 32'(item.cell_index) < CELL_COUNT;
	assign item_ready  = (state_q == ST_IDLE);
	assign res_valid   = (state_q == ST_DONE);

	// put decode on the current cursor
	always_comb begin
		rowx      = {1'b0, row_q};
		colx      = {1'b0, col_q};
		nrow      = rowx;
		ncol      = colx;
		col_t     = colx;
		put_we    = 1'b0;
		put_waddr = cur_addr;
		put_wdata = {cfg.attr, item.char_code};
		go_bs     = 1'b0;
		case (item.char_code)
			CH_NEWLINE: begin
				nrow = rowx + 1'b1;
				ncol = '0;
			end
			CH_TAB: begin
				col_t      = colx + (CW+1)'(TAB_STEP);
				col_t[1:0] = 2'b00;
				if (col_t >= (CW+1)'(SCREEN_COLS)) begin
					nrow = rowx + 1'b1;
					ncol = '0;
				end else begin
					ncol = col_t;
				end
			end
			CH_BACKSPACE: begin
				if (col_q != '0) begin
					ncol      = colx - 1'b1;
					put_we    = 1'b1;
					put_waddr = cur_addr - ADDR_W'(1);
					put_wdata = cfg.blank;
				end else if (row_q != '0) begin
					nrow  = rowx - 1'b1;
					ncol  = (CW+1)'(SCREEN_COLS - 1);
					go_bs = 1'b1;
				end
			end
			default: begin
				put_we = 1'b1;
				col_t  = colx + 1'b1;
				if (col_t >= (CW+1)'(SCREEN_COLS)) begin
					nrow = rowx + 1'b1;
					ncol = '0;
				end else begin
					ncol = col_t;
				end
			end
		endcase
		wrap_scroll = (nrow == (RW+1)'(SCREEN_ROWS));
	end

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = cfg.blank;
		mem_raddr = cur_addr;
		case (state_q)
			ST_IDLE: begin
				mem_we    = item_valid && (item.req_type == REQ_PUT) && put_we;
				mem_waddr = put_waddr;
				mem_wdata = put_wdata;
				mem_raddr = ADDR_W'(item.cell_index);
			end
			ST_BS_CMP: begin
				mem_we = !scan_more;
			end
			ST_COPY: begin
				mem_we    = cp_vld_s1;
				mem_waddr = cp_addr_s1;
				mem_wdata = mem_rdata;
				mem_raddr = ADDR_W'(cnt_q + CNT_W'(SCREEN_COLS));
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cnt_q);
				mem_wdata = clr_q ? BLANK_RESET : cfg.blank;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			cnt_q     <= '0;
			clr_q     <= 1'b1;
			row_q     <= '0;
			col_q     <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == ST_COPY) && (cnt_q != CNT_W'(COPY_N));
			case (state_q)
				ST_FILL: begin
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						clr_q   <= 1'b0;
						state_q <= clr_q ? ST_IDLE : ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						if (item.req_type == REQ_READ) begin
							state_q <= ST_RD;
						end else if (go_bs) begin
							row_q   <= RW'(nrow);
							col_q   <= CW'(ncol);
							state_q <= ST_BS_RD;
						end else if (wrap_scroll) begin
							row_q   <= RW'(SCREEN_ROWS - 1);
							col_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_COPY;
						end else begin
							row_q   <= RW'(nrow);
							col_q   <= CW'(ncol);
							state_q <= ST_DONE;
						end
					end
				end
				ST_RD:    state_q <= ST_DONE;
				ST_BS_RD: state_q <= ST_BS_CMP;
				ST_BS_CMP: begin
					if (scan_more) begin
						col_q   <= col_q - 1'b1;
						state_q <= ST_BS_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_COPY: begin
					if (cnt_q == CNT_W'(COPY_N))
						state_q <= ST_FILL;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ADDR_W'(cnt_q);
		if (state_q == ST_IDLE && item_valid) begin
			value_q <= '0;
			scr_q   <= (item.req_type == REQ_PUT) && !go_bs && wrap_scroll;
			rd_ok_q <= in_range;
		end
		if (state_q == ST_RD)
			value_q <= rd_ok_q ? mem_rdata : '0;
	end

	assign res.cell_value = value_q;
	assign res.cursor_row = ROW_OUT_W'(row_q);
	assign res.cursor_col = COL_OUT_W'(col_q);
	assign res.cursor_pos = POS_W'(cur_addr);
	assign res.scrolled   = scr_q;

`ifndef NO_ASSERTIONS
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < SCREEN_ROWS) && (32'(col_q) < SCREEN_COLS))
		else $error("cursor left the screen");
	a_copy_dest: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (32'(cp_addr_s1) < COPY_N))
		else $error("scroll copy wrote into the bottom line");
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BS_CMP) |-> ($past(state_q) == ST_BS_RD))
		else $error("backspace compare without a read");
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !clr_q)
		else $error("request taken during clearing pass");
`endif

endmodule

`default_nettype wire

@@ rtl/text_console_char_writer_core.sv @@
// Top level of the text console character writer: config registers, output register.
//
//  channel | role | handshake          | contents
//  --------+------+--------------------+-------------------------------------------
//  req     | sink | valid/ready        | req_type, char_code, cell_index
//  rsp     | src  | valid/ready        | cell_value, cursor_row/col/pos, scrolled
//  cfg     | sink | cfg_we (no stall)  | cfg_index, cfg_data
//
// Sequencing: a read passes through a read state before its result; a backspace at
// column zero scans the line above cell by cell, reading then comparing each cell; a
// scroll copies the lines up by one row and blank-fills the bottom line, all through
// the single read and single write port of the screen store.
// Reset: arst_n clears the cursor and starts a clearing pass over all SCREEN_ROWS*SCREEN_COLS
// cells with req.ready low; cfg writes are taken throughout.
// Stalls: rsp is registered, so a new req transaction is taken while a result waits.
`default_nettype none

module text_console_char_writer_core import tcw_pkg::*; #(
	parameter int SCREEN_ROWS = 25,
	parameter int SCREEN_COLS = 80
) (
	input  wire                  clk,
	input  wire                  arst_n,
	tcw_req_if.sink              req,
	tcw_rsp_if.source            rsp,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(SCREEN_ROWS * SCREEN_COLS);

	cfg_t              cfg_q;
	req_item_t         item;
	rsp_item_t         eng_res;
	rsp_item_t         rsp_q;
	logic              rsp_vld_q;
	logic              eng_res_valid;
	logic              eng_res_ready;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	// configuration registers; taken on any cycle with cfg_we high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attr  <= ATTR_RESET;
			cfg_q.blank <= BLANK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_ATTR:  cfg_q.attr  <= cfg_data[ATTR_W-1:0];
				REG_BLANK_CELL: cfg_q.blank <= cfg_data[CELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign item.req_type   = req.req_type;
	assign item.char_code  = req.char_code;
	assign item.cell_index = req.cell_index;

	tcw_engine #(
		.SCREEN_ROWS (SCREEN_ROWS),
		.SCREEN_COLS (SCREEN_COLS),
		.ADDR_W      (ADDR_W)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (req.valid),
		.item_ready (req.ready),
		.item       (item),
		.res_valid  (eng_res_valid),
		.res_ready  (eng_res_ready),
		.res        (eng_res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tcw_mem #(
		.DEPTH  (SCREEN_ROWS * SCREEN_COLS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result register: takes the engine's result when empty or draining
	assign eng_res_ready = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_vld_q <= 1'b0;
		else if (eng_res_valid && eng_res_ready)
			rsp_vld_q <= 1'b1;
		else if (rsp.ready)
			rsp_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && eng_res_ready)
			rsp_q <= eng_res;
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.cell_value = rsp_q.cell_value;
	assign rsp.cursor_row = rsp_q.cursor_row;
	assign rsp.cursor_col = rsp_q.cursor_col;
	assign rsp.cursor_pos = rsp_q.cursor_pos;
	assign rsp.scrolled   = rsp_q.scrolled;

endmodule

`default_nettype wire
